### sv/hcb_pkg.sv
// Shared types and constants for the Huffman code builder.
package hcb_pkg;
  localparam int FREQ_W = 16;
  localparam int WEIGHT_W = 20;
  localparam int SYM_W = 4;
  localparam int CODE_W = 15;
  localparam int LEN_W = 4;
  localparam int ID_W = 5;

  typedef struct packed {
    logic load;
    logic init;
    logic scan_start;
    logic scan_step;
    logic merge;
    logic walk_start;
    logic walk_step;
    logic emit_start;
    logic emit_next;
  } hcb_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic build_done;
    logic walk_done;
    logic emit_last;
  } hcb_sts_t;
endpackage

### sv/huffman_code_builder_top.sv
// Huffman code builder: frequencies in, one code word per symbol out.
// Usage:
//   Input channel: in_valid/in_ready with in_frequency, one beat per symbol
//   in symbol order. After NumSymbols beats the tree is built and the
//   block emits NumSymbols result beats on out_valid/out_ready, in symbol
//   order, last_code marking the final one.
//   in_ready stays high while a run is loaded. Building runs one scan of
//   the active list per merge, then the tree walk, one merged node per
//   cycle. Results then leave at one per cycle while out_ready is high.
//   in_ready is low while a run is built and emitted; a stalled receiver
//   simply holds the current result. Synchronous active-low reset drops
//   any partly loaded run.
module huffman_code_builder_top import hcb_pkg::*; #(
  parameter int NumSymbols = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [FREQ_W-1:0] in_frequency,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SYM_W-1:0]  out_symbol_index,
  output logic [CODE_W-1:0] out_code_bits,
  output logic [LEN_W-1:0]  out_code_length,
  output logic              out_last_code
);
  hcb_cmd_t cmd;
  hcb_sts_t sts;
  logic [SYM_W-1:0] load_idx;

  hcb_ctrl #(.NumSymbols(NumSymbols)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .load_idx, .cmd, .sts
  );

  hcb_datapath #(.NumSymbols(NumSymbols)) u_dp (
    .clk, .cmd, .sts, .load_freq(in_frequency), .load_idx,
    .sym_idx(out_symbol_index), .sym_bits(out_code_bits), .sym_len(out_code_length)
  );

  assign out_last_code = sts.emit_last;

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("in and out both open");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_symbol_index))
    else $error("result moved under stall");
`endif
endmodule

### sv/hcb_datapath.sv
// Datapath: node storage, min-two scan, merge, code walk, emit.
module hcb_datapath import hcb_pkg::*; #(
  parameter int NumSymbols = 6
) (
  input  logic               clk,
  input  hcb_cmd_t           cmd,
  output hcb_sts_t           sts,
  input  logic [FREQ_W-1:0]  load_freq,
  input  logic [SYM_W-1:0]   load_idx,
  output logic [SYM_W-1:0]   sym_idx,
  output logic [CODE_W-1:0]  sym_bits,
  output logic [LEN_W-1:0]   sym_len
);
  localparam int NodeCount = 2 * NumSymbols - 1;
  localparam int MergeCount = NumSymbols - 1;
  localparam int AW = $clog2(NumSymbols + 1);
  localparam int NW = $clog2(NodeCount);
  localparam int MW = $clog2(MergeCount + 1);

  logic [WEIGHT_W-1:0] weight_r [NodeCount];
  logic [ID_W-1:0]     zc_r [MergeCount];
  logic [ID_W-1:0]     oc_r [MergeCount];
  logic [ID_W-1:0]     act_r [NumSymbols];
  logic [AW-1:0]       cnt_r;
  logic [AW-1:0]       pos_r;
  logic [AW-1:0]       p0_r, p1_r;
  logic [ID_W-1:0]     m_r;
  logic [CODE_W-1:0]   pbits_r [NodeCount];
  logic [LEN_W-1:0]    plen_r [NodeCount];
  logic [ID_W-1:0]     wm_r;
  logic [SYM_W-1:0]    emit_r;

  logic [WEIGHT_W-1:0] wt, w0, w1;
  logic [ID_W-1:0]     fresh, par;
  logic [CODE_W-1:0]   pb;
  logic [LEN_W-1:0]    pl;

  assign wt = weight_r[act_r[pos_r[$clog2(NumSymbols)-1:0]][NW-1:0]];
  assign w0 = weight_r[act_r[p0_r[$clog2(NumSymbols)-1:0]][NW-1:0]];
  assign w1 = weight_r[act_r[p1_r[$clog2(NumSymbols)-1:0]][NW-1:0]];
  assign fresh = ID_W'(NumSymbols) + m_r;
  assign par = ID_W'(NumSymbols) + wm_r;
  assign pb = pbits_r[par[NW-1:0]];
  assign pl = plen_r[par[NW-1:0]];

  assign sts.scan_done = (pos_r >= cnt_r);
  assign sts.build_done = (m_r == ID_W'(MergeCount));
  assign sts.walk_done = (wm_r == '0);
  assign sts.emit_last = (emit_r == SYM_W'(NumSymbols - 1));
  assign sym_idx = emit_r;
  assign sym_bits = pbits_r[emit_r];
  assign sym_len = plen_r[emit_r];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      weight_r[load_idx] <= WEIGHT_W'(load_freq);
    end
    if (cmd.init) begin
      for (int i = 0; i < NumSymbols; i++) act_r[i] <= ID_W'(i);
      cnt_r <= AW'(NumSymbols);
      m_r <= '0;
    end
    if (cmd.scan_start) begin
      if (weight_r[act_r[1][NW-1:0]] < weight_r[act_r[0][NW-1:0]]) begin
        p0_r <= AW'(1);
        p1_r <= '0;
      end else begin
        p0_r <= '0;
        p1_r <= AW'(1);
      end
      pos_r <= AW'(2);
    end
    if (cmd.scan_step) begin
      if (wt < w0) begin
        p1_r <= p0_r;
        p0_r <= pos_r;
      end else if (wt < w1) begin
        p1_r <= pos_r;
      end
      pos_r <= pos_r + 1'b1;
    end
    if (cmd.merge) begin
      zc_r[m_r[MW-1:0]] <= act_r[p0_r[$clog2(NumSymbols)-1:0]];
      oc_r[m_r[MW-1:0]] <= act_r[p1_r[$clog2(NumSymbols)-1:0]];
      weight_r[fresh[NW-1:0]] <= w0 + w1;
      for (int i = 0; i < NumSymbols; i++) begin
        if (AW'(i) < cnt_r - 2'd2) begin
          if (AW'(i) < ((p0_r < p1_r) ? p0_r : p1_r)) act_r[i] <= act_r[i];
          else if (AW'(i) + 1'b1 < ((p0_r > p1_r) ? p0_r : p1_r))
            act_r[i] <= act_r[(i + 1) % NumSymbols];
          else act_r[i] <= act_r[(i + 2) % NumSymbols];
        end else if (AW'(i) == cnt_r - 2'd2) begin
          act_r[i] <= fresh;
        end
      end
      cnt_r <= cnt_r - 1'b1;
      m_r <= m_r + 1'b1;
    end
    if (cmd.walk_start) begin
      pbits_r[NodeCount-1] <= '0;
      plen_r[NodeCount-1] <= '0;
      wm_r <= ID_W'(MergeCount - 1);
    end
    if (cmd.walk_step) begin
      pbits_r[zc_r[wm_r[MW-1:0]][NW-1:0]] <= {pb[CODE_W-2:0], 1'b0};
      plen_r[zc_r[wm_r[MW-1:0]][NW-1:0]] <= pl + 1'b1;
      pbits_r[oc_r[wm_r[MW-1:0]][NW-1:0]] <= {pb[CODE_W-2:0], 1'b1};
      plen_r[oc_r[wm_r[MW-1:0]][NW-1:0]] <= pl + 1'b1;
      wm_r <= wm_r - 1'b1;
    end
    if (cmd.emit_start) emit_r <= '0;
    if (cmd.emit_next) emit_r <= emit_r + 1'b1;
  end
endmodule

### sv/hcb_ctrl.sv
// Controller: load, build, walk and emit sequencing.
module hcb_ctrl import hcb_pkg::*; #(
  parameter int NumSymbols = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [SYM_W-1:0] load_idx,
  output hcb_cmd_t         cmd,
  input  hcb_sts_t         sts
);
  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_MERGE = 3'd3;
  localparam logic [2:0] S_WALK0 = 3'd4;
  localparam logic [2:0] S_WALK = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [SYM_W:0] cnt_r, cnt_nxt;
  logic in_acc, out_acc;

  assign in_ready = (state_r == S_LOAD);
  assign out_valid = (state_r == S_EMIT);
  assign in_acc = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign load_idx = cnt_r[SYM_W-1:0];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd = '0;
    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          cmd.load = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == (SYM_W+1)'(NumSymbols - 1)) begin
            cnt_nxt = '0;
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.init = 1'b1;
        state_nxt = S_MERGE;
      end
      S_MERGE: begin
        if (sts.build_done) begin
          state_nxt = S_WALK0;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          cmd.merge = 1'b1;
          state_nxt = S_MERGE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_WALK0: begin
        cmd.walk_start = 1'b1;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_done) begin
          cmd.emit_start = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_acc) begin
          cmd.emit_next = 1'b1;
          if (sts.emit_last) state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule

### tb/tb.sv
// Testbench for huffman_code_builder_top: frequency runs in, per-symbol codes checked.
`timescale 1ns / 1ps
module tb import hcb_pkg::*; ();

  localparam int NSYM = 6;
  localparam int NNODE = 2 * NSYM - 1;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  len;
    logic              last;
  } code_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [FREQ_W-1:0] in_frequency = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [SYM_W-1:0] out_symbol_index;
  logic [CODE_W-1:0] out_code_bits;
  logic [LEN_W-1:0] out_code_length;
  logic out_last_code;

  code_t code_q[$];
  logic [FREQ_W-1:0] run_freqs[NSYM];
  int loaded = 0;
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;

  huffman_code_builder_top #(.NumSymbols(NSYM)) dut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Builds the tree for one run of frequencies and queues the codes.
  task automatic predict_codes();
    logic [WEIGHT_W-1:0] wt[NNODE];
    int zc[NSYM-1], oc[NSYM-1];
    int act[NSYM];
    int cnt, p0, p1, lo, hi, w, par;
    logic [CODE_W-1:0] pb[NNODE];
    int pl[NNODE];
    code_t c;
    for (int i = 0; i < NSYM; i++) begin
      wt[i] = WEIGHT_W'(run_freqs[i]);
      act[i] = i;
    end
    cnt = NSYM;
    for (int m = 0; m < NSYM - 1; m++) begin
      p0 = 0;
      p1 = 1;
      if (wt[act[1]] < wt[act[0]]) begin
        p0 = 1;
        p1 = 0;
      end
      for (int i = 2; i < cnt; i++) begin
        if (wt[act[i]] < wt[act[p0]]) begin
          p1 = p0;
          p0 = i;
        end else if (wt[act[i]] < wt[act[p1]]) begin
          p1 = i;
        end
      end
      zc[m] = act[p0];
      oc[m] = act[p1];
      wt[NSYM + m] = wt[act[p0]] + wt[act[p1]];
      lo = p0 < p1 ? p0 : p1;
      hi = p0 < p1 ? p1 : p0;
      w = 0;
      for (int i = 0; i < cnt; i++)
        if (i != lo && i != hi) begin
          act[w] = act[i];
          w++;
        end
      act[w] = NSYM + m;
      cnt = w + 1;
    end
    pb[NNODE-1] = '0;
    pl[NNODE-1] = 0;
    for (int m = NSYM - 2; m >= 0; m--) begin
      par = NSYM + m;
      pb[zc[m]] = {pb[par][CODE_W-2:0], 1'b0};
      pl[zc[m]] = pl[par] + 1;
      pb[oc[m]] = {pb[par][CODE_W-2:0], 1'b1};
      pl[oc[m]] = pl[par] + 1;
    end
    for (int s = 0; s < NSYM; s++) begin
      c.sym = SYM_W'(s);
      c.bits = pb[s];
      c.len = LEN_W'(pl[s]);
      c.last = (s == NSYM - 1);
      code_q.insert(code_q.size(), c);
    end
  endtask

  task automatic send_freq(input logic [FREQ_W-1:0] f);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_frequency <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    run_freqs[loaded] = f;
    loaded++;
    if (loaded == NSYM) begin
      predict_codes();
      loaded = 0;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (code_q.size() == 0) begin
        $error("unexpected code beat for symbol %0d", out_symbol_index);
        errors++;
      end else begin
        code_t e;
        e = code_q.pop_front();
        if (out_symbol_index !== e.sym) begin
          $error("symbol_index exp %0d got %0d", e.sym, out_symbol_index);
          errors++;
        end
        if (out_code_bits !== e.bits) begin
          $error("code_bits exp %h got %h", e.bits, out_code_bits);
          errors++;
        end
        if (out_code_length !== e.len) begin
          $error("code_length exp %0d got %0d", e.len, out_code_length);
          errors++;
        end
        if (out_last_code !== e.last) begin
          $error("last_code exp %0d got %0d", e.last, out_last_code);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_ready <= 0;
      hold_off <= hold_off - 1;
    end else begin
      out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic test_directed();
    logic [FREQ_W-1:0] runs[4][NSYM] = '{
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
      '{16'd1, 16'd2, 16'd4, 16'd8, 16'd16, 16'd32},
      '{16'hFFFF, 16'd0, 16'h5555, 16'hAAAA, 16'd7, 16'd7}};
    foreach (runs[r, i]) send_freq(runs[r][i]);
  endtask

  function automatic logic [FREQ_W-1:0] rand_freq();
    case ($urandom_range(3))
      0: return FREQ_W'($urandom_range(3));
      1: return FREQ_W'($urandom_range(40));
      2: return FREQ_W'(16'hFFFF - $urandom_range(3));
      default: return FREQ_W'($urandom);
    endcase
  endfunction

  task automatic test_random(input int nitems, input int idle, input int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (nitems) send_freq(rand_freq());
  endtask

  task automatic test_backpressure();
    hold_off <= 300;
    repeat (3 * NSYM) send_freq(rand_freq());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_random(66, 0, 0);
    test_random(66, 64, 0);
    test_random(66, 0, 64);
    test_random(66, 14, 14);
    test_backpressure();
    in_valid <= 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (code_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
